/* src/hmc_pkg.sv */
package hmc_pkg;

    localparam int ENTRY_COUNT = 27;
    localparam int MAX_TOKEN   = 16;
    localparam int TEXT_BITS   = MAX_TOKEN * 8;

    localparam logic [4:0] LEN_SAT    = 5'd17;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [4:0] CODE_NONE  = 5'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [4:0] method_code;
        logic [4:0] token_length;
    } out_item_t;

    // Method names, right-justified: byte i of an entry of length n sits at bits (n-1-i)*8.
    localparam logic [TEXT_BITS-1:0] DICT_TEXT [ENTRY_COUNT] = '{
        "GET", "PUT", "POST", "DELETE", "CONNECT", "OPTIONS", "TRACE", "PATCH",
        "PROPFIND", "PROPPATCH", "MKCOL", "COPY", "MOVE", "LOCK", "UNLOCK",
        "VERSION-CONTROL", "CHECKOUT", "UNCHECKOUT", "CHECKIN", "UPDATE", "LABEL",
        "REPORT", "MKWORKSPACE", "MKACTIVITY", "BASELINE-CONTROL", "MERGE", "HEAD"
    };

    localparam logic [4:0] DICT_LEN [ENTRY_COUNT] = '{
        5'd3, 5'd3, 5'd4, 5'd6, 5'd7, 5'd7, 5'd5, 5'd5, 5'd8, 5'd9, 5'd5, 5'd4,
        5'd4, 5'd4, 5'd6, 5'd15, 5'd8, 5'd10, 5'd7, 5'd6, 5'd5, 5'd6, 5'd11,
        5'd10, 5'd16, 5'd5, 5'd4
    };

    // HEAD shares the GET code.
    localparam logic [4:0] DICT_CODE [ENTRY_COUNT] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd1
    };

endpackage

/* src/http_method_classifier.sv */
// The result is registered; it reaches the m_ side in the cycle after the item that ends the token.
// Throughput: one byte item per cycle while s_ready is high; each token byte narrows all 27 candidates at once.
// The result register frees s_ready whenever it is empty or being taken.
// Reset (aresetn low, synchronous): new run, all candidates live, no result pending.
module http_method_classifier (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hmc_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hmc_pkg::out_item_t m_data
);

    logic [4:0]                      pos_reg, pos_next;
    logic [hmc_pkg::ENTRY_COUNT-1:0] mask_reg, mask_next;
    logic                            fin_reg, fin_next;
    logic                            m_valid_reg, m_valid_next;
    hmc_pkg::out_item_t              m_data_reg, m_data_next;

    logic                            accept;
    logic                            emit;
    logic [4:0]                      pos_inc;
    logic [4:0]                      emit_len;
    logic [hmc_pkg::ENTRY_COUNT-1:0] emit_mask;
    logic [hmc_pkg::ENTRY_COUNT-1:0] narrowed;
    logic [3:0]                      char_idx [hmc_pkg::ENTRY_COUNT];
    logic [4:0]                      code;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pos_inc = (pos_reg < hmc_pkg::LEN_SAT) ? pos_reg + 5'd1 : pos_reg;

    // Keep an entry only if it is still live and its next letter matches.
    always_comb begin
        for (int e = 0; e < hmc_pkg::ENTRY_COUNT; e++) begin
            char_idx[e] = hmc_pkg::DICT_LEN[e][3:0] - 4'd1 - pos_reg[3:0];
            narrowed[e] = mask_reg[e] && (pos_reg < hmc_pkg::DICT_LEN[e]) &&
                          (hmc_pkg::DICT_TEXT[e][{char_idx[e], 3'b000} +: 8] ==
                           s_data.data_byte);
        end
    end

    always_comb begin
        pos_next  = pos_reg;
        mask_next = mask_reg;
        fin_next  = fin_reg;
        emit      = 1'b0;
        emit_len  = pos_reg;
        emit_mask = mask_reg;
        if (accept) begin
            if (fin_reg) begin
                if (s_data.is_last) begin
                    pos_next  = '0;
                    mask_next = '1;
                    fin_next  = 1'b0;
                end
            end else if (s_data.data_byte == hmc_pkg::SPACE_CHAR) begin
                emit = 1'b1;
                if (s_data.is_last) begin
                    pos_next  = '0;
                    mask_next = '1;
                end else begin
                    fin_next = 1'b1;
                end
            end else if (s_data.is_last) begin
                emit      = 1'b1;
                emit_len  = pos_inc;
                emit_mask = narrowed;
                pos_next  = '0;
                mask_next = '1;
            end else begin
                pos_next  = pos_inc;
                mask_next = narrowed;
            end
        end
    end

    // Lowest live entry of matching length wins; at most one can match anyway.
    always_comb begin
        code = hmc_pkg::CODE_NONE;
        if (emit_len >= 5'd1 && emit_len <= 5'(hmc_pkg::MAX_TOKEN)) begin
            for (int e = hmc_pkg::ENTRY_COUNT - 1; e >= 0; e--) begin
                if (emit_mask[e] && emit_len == hmc_pkg::DICT_LEN[e]) begin
                    code = hmc_pkg::DICT_CODE[e];
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.method_code  = code;
            m_data_next.token_length = emit_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            mask_reg    <= '1;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            mask_reg    <= mask_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

typedef enum logic [4:0] {
    METHOD_UNKNOWN, METHOD_GET, METHOD_PUT, METHOD_POST, METHOD_DELETE, METHOD_CONNECT,
    METHOD_OPTIONS, METHOD_TRACE, METHOD_PATCH, METHOD_PROPFIND, METHOD_PROPPATCH,
    METHOD_MKCOL, METHOD_COPY, METHOD_MOVE, METHOD_LOCK, METHOD_UNLOCK,
    METHOD_VERSION_CONTROL, METHOD_CHECKOUT, METHOD_UNCHECKOUT, METHOD_CHECKIN,
    METHOD_UPDATE, METHOD_LABEL, METHOD_REPORT, METHOD_MKWORKSPACE, METHOD_MKACTIVITY,
    METHOD_BASELINE_CONTROL, METHOD_MERGE
} method_e;

class method_checker;
    string              names [hmc_pkg::ENTRY_COUNT];
    method_e            codes [hmc_pkg::ENTRY_COUNT];
    logic [4:0]         char_count;
    logic [26:0]        live_mask;
    bit                 swallowing;
    hmc_pkg::out_item_t expected_methods [$];
    int                 errors;

    function new();
        names = '{"GET", "PUT", "POST", "DELETE", "CONNECT", "OPTIONS", "TRACE", "PATCH",
                  "PROPFIND", "PROPPATCH", "MKCOL", "COPY", "MOVE", "LOCK", "UNLOCK",
                  "VERSION-CONTROL", "CHECKOUT", "UNCHECKOUT", "CHECKIN", "UPDATE",
                  "LABEL", "REPORT", "MKWORKSPACE", "MKACTIVITY", "BASELINE-CONTROL",
                  "MERGE", "HEAD"};
        // HEAD reports as GET
        codes = '{METHOD_GET, METHOD_PUT, METHOD_POST, METHOD_DELETE, METHOD_CONNECT,
                  METHOD_OPTIONS, METHOD_TRACE, METHOD_PATCH, METHOD_PROPFIND,
                  METHOD_PROPPATCH, METHOD_MKCOL, METHOD_COPY, METHOD_MOVE, METHOD_LOCK,
                  METHOD_UNLOCK, METHOD_VERSION_CONTROL, METHOD_CHECKOUT,
                  METHOD_UNCHECKOUT, METHOD_CHECKIN, METHOD_UPDATE, METHOD_LABEL,
                  METHOD_REPORT, METHOD_MKWORKSPACE, METHOD_MKACTIVITY,
                  METHOD_BASELINE_CONTROL, METHOD_MERGE, METHOD_GET};
        errors = 0;
        restart();
    endfunction

    function void restart();
        char_count = '0;
        live_mask  = '1;
        swallowing = 1'b0;
    endfunction

    function method_e lookup(logic [4:0] n);
        if (n < 1 || n > hmc_pkg::MAX_TOKEN)
            return METHOD_UNKNOWN;
        for (int e = 0; e < hmc_pkg::ENTRY_COUNT; e++)
            if (live_mask[e] && names[e].len() == n)
                return codes[e];
        return METHOD_UNKNOWN;
    endfunction

    function void queue_method();
        hmc_pkg::out_item_t r;
        r.method_code  = lookup(char_count);
        r.token_length = char_count;
        expected_methods.push_back(r);
    endfunction

    // Returns 1 when the item took part in a token (not swallowed).
    function bit take_byte(hmc_pkg::in_item_t it);
        if (swallowing) begin
            if (it.is_last)
                restart();
            return 1'b0;
        end
        if (it.data_byte == hmc_pkg::SPACE_CHAR) begin
            queue_method();
            if (it.is_last)
                restart();
            else
                swallowing = 1'b1;
            return 1'b1;
        end
        for (int e = 0; e < hmc_pkg::ENTRY_COUNT; e++)
            if (live_mask[e] && (char_count >= names[e].len() ||
                                 names[e][char_count] != it.data_byte))
                live_mask[e] = 1'b0;
        if (char_count < hmc_pkg::LEN_SAT)
            char_count++;
        if (it.is_last) begin
            queue_method();
            restart();
        end
        return 1'b1;
    endfunction

    function void check_method(hmc_pkg::out_item_t got);
        hmc_pkg::out_item_t want;
        if (expected_methods.size() == 0) begin
            $display("%0t: unexpected result code %0d length %0d",
                     $time, got.method_code, got.token_length);
            errors++;
            return;
        end
        want = expected_methods.pop_front();
        if (got.method_code !== want.method_code) begin
            $display("%0t: method_code expected %0d, got %0d",
                     $time, want.method_code, got.method_code);
            errors++;
        end
        if (got.token_length !== want.token_length) begin
            $display("%0t: token_length expected %0d, got %0d",
                     $time, want.token_length, got.token_length);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    hmc_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    hmc_pkg::out_item_t m_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int live_bytes     = 0;

    method_checker tracker = new();

    http_method_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            tracker.check_method(m_data);
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] rand_token_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == hmc_pkg::SPACE_CHAR);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit ends);
        hmc_pkg::in_item_t it;
        it.data_byte = b;
        it.is_last   = ends;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(tracker.take_byte(it));
        live_bytes++;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_text(input string t, input bit ends);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i], ends && i == t.len() - 1);
    endtask

    // space, then a few swallowed bytes up to the last flag
    task automatic send_space_tail();
        int tail;
        tail = $urandom_range(6);
        send_byte(hmc_pkg::SPACE_CHAR, tail == 0);
        for (int i = 0; i < tail; i++)
            send_byte(8'($urandom_range(255)), i == tail - 1);
    endtask

    task automatic send_random_run();
        int    kind;
        int    n;
        bit    spaced;
        string s;
        kind   = $urandom_range(99);
        spaced = 1'($urandom_range(1));
        s      = tracker.names[$urandom_range(hmc_pkg::ENTRY_COUNT - 1)];
        if (kind < 55) begin
            send_text(s, !spaced);
            if (spaced) send_space_tail();
        end else if (kind < 72) begin
            case ($urandom_range(2))
                0: begin
                    s.putc($urandom_range(s.len() - 1), byte'($urandom_range(8'h21, 8'hFF)));
                    send_text(s, !spaced);
                end
                1: send_text(s.substr(0, s.len() - 2), !spaced);
                default: begin
                    send_text(s, 1'b0);
                    send_byte(rand_token_byte(), !spaced);
                end
            endcase
            if (spaced) send_space_tail();
        end else if (kind < 84) begin
            // lengths around the 16-byte limit, sometimes far past saturation
            n = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(14, 20);
            for (int i = 0; i < n; i++)
                send_byte(rand_token_byte(), !spaced && i == n - 1);
            if (spaced) send_space_tail();
        end else if (kind < 92) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)), i == n - 1);
        end else begin
            // empty token
            if (spaced) send_space_tail();
            else send_byte(hmc_pkg::SPACE_CHAR, 1'b1);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(hmc_pkg::SPACE_CHAR, 1'b1);
        send_text("HEAD", 1'b1);
        send_text("PUT ", 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("VERSION-CONTROL", 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            while (live_bytes < 26 + (ph + 1) * 231)
                send_random_run();
        end
        s_valid <= 1'b0;

        while (tracker.expected_methods.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (tracker.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
